[hdl/apcifc_pkg.sv]
// Shared types and constants of the APCI frame checker.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package apcifc_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_FRAME_LEN   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_FRAME_LEN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_STATION_ADDRESS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_LIMIT       = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_I     = 3'd0;
  localparam logic [2:0] KIND_S     = 3'd1;
  localparam logic [2:0] KIND_U     = 3'd2;
  localparam logic [2:0] KIND_ERROR = 3'd3;
  localparam logic [2:0] KIND_TX    = 3'd4;

  // Error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_LENGTH   = 2'd1;
  localparam logic [1:0] ERR_ADDRESS  = 2'd2;
  localparam logic [1:0] ERR_ACK_HIGH = 2'd3;

  // Protocol constants
  localparam logic [7:0]  START_BYTE    = 8'h68;
  localparam logic [8:0]  I_FRAME_MIN   = 9'd12;
  localparam logic [8:0]  SU_FRAME_LEN  = 9'd6;
  localparam logic [15:0] ADDR_BCAST_LO = 16'h00FF;
  localparam logic [15:0] ADDR_BCAST_HI = 16'hFFFF;
  localparam logic [16:0] SEQ_STEP      = 17'd2;

  // Register reset values
  localparam logic [8:0]  RST_MAX_FRAME_LEN   = 9'd255;
  localparam logic [3:0]  RST_MIN_FRAME_LEN   = 4'd6;
  localparam logic [15:0] RST_STATION_ADDRESS = 16'h0001;
  localparam logic [15:0] RST_SEQ_LIMIT       = 16'd65534;

  typedef enum logic [1:0] {
    PH_HUNT = 2'd0,
    PH_LEN  = 2'd1,
    PH_BODY = 2'd2
  } phase_t;

  typedef struct packed {
    logic [8:0]  max_frame_len;
    logic [3:0]  min_frame_len;
    logic [15:0] station_address;
    logic [15:0] seq_limit;
  } cfg_t;

  // One queued job: a gathered frame or a transmit mark
  typedef struct packed {
    logic        is_tx;
    logic [8:0]  total;
    logic [31:0] control;
    logic [15:0] address;
  } job_t;

endpackage

`default_nettype wire

[hdl/apcifc_front.sv]
// Front end: start byte hunt, length byte and frame gathering.
// Depends on apcifc_pkg; pushes one job per finished frame or transmit mark.
`timescale 1ns / 1ps
`default_nettype none

module apcifc_front
  import apcifc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       accept,
  input  wire logic       func,
  input  wire logic [7:0] rx_byte,
  output logic            push,
  output job_t            push_job
);

  phase_t      phase, phase_next;
  logic [8:0]  byte_index, byte_index_next;
  logic [7:0]  frame_length, frame_length_next;
  logic [31:0] control_bytes, control_bytes_next;
  logic [15:0] address_bytes, address_bytes_next;
  logic [8:0]  total;

  assign total = {1'b0, frame_length} + 9'd2;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_index    <= '0;
      frame_length  <= '0;
      control_bytes <= '0;
      address_bytes <= '0;
    end else begin
      phase         <= phase_next;
      byte_index    <= byte_index_next;
      frame_length  <= frame_length_next;
      control_bytes <= control_bytes_next;
      address_bytes <= address_bytes_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    byte_index_next    = byte_index;
    frame_length_next  = frame_length;
    control_bytes_next = control_bytes;
    address_bytes_next = address_bytes;
    push               = 1'b0;
    push_job.is_tx     = func;
    push_job.total     = total;
    push_job.control   = control_bytes;
    push_job.address   = address_bytes;
    if (accept) begin
      if (func) begin
        push = 1'b1;
      end else begin
        case (phase)
          PH_LEN: begin
            if (rx_byte == 8'd0) begin
              phase_next      = PH_HUNT;
              byte_index_next = '0;
            end else begin
              frame_length_next  = rx_byte;
              byte_index_next    = 9'd2;
              control_bytes_next = '0;
              address_bytes_next = '0;
              phase_next         = PH_BODY;
            end
          end
          PH_BODY: begin
            case (byte_index)
              9'd2:  control_bytes_next[7:0]   = rx_byte;
              9'd3:  control_bytes_next[15:8]  = rx_byte;
              9'd4:  control_bytes_next[23:16] = rx_byte;
              9'd5:  control_bytes_next[31:24] = rx_byte;
              9'd10: address_bytes_next[7:0]   = rx_byte;
              9'd11: address_bytes_next[15:8]  = rx_byte;
              default: ;
            endcase
            byte_index_next = byte_index + 9'd1;
            // last byte of the frame: hand the whole frame to the back end
            if (byte_index_next >= total) begin
              phase_next      = PH_HUNT;
              byte_index_next = '0;
              push            = 1'b1;
            end
            push_job.control = control_bytes_next;
            push_job.address = address_bytes_next;
          end
          default: begin
            phase_next = PH_HUNT;
            if (rx_byte == START_BYTE) begin
              phase_next      = PH_LEN;
              byte_index_next = 9'd1;
            end
          end
        endcase
      end
    end
  end

endmodule

`default_nettype wire

[hdl/apcifc_queue.sv]
// Short job queue between front and back end.
// Depends on apcifc_pkg for the job type.
`timescale 1ns / 1ps
`default_nettype none

module apcifc_queue
  import apcifc_pkg::*;
#(
  parameter int DEPTH = 4
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  output logic      full,
  output logic      head_valid,
  output job_t      head_job,
  input  wire logic pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  job_t             entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

[hdl/apcifc_back.sv]
// Back end: frame checks, sequence counters and the output register.
// Depends on apcifc_pkg; consumes jobs from apcifc_queue.
`timescale 1ns / 1ps
`default_nettype none

module apcifc_back
  import apcifc_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire cfg_t   cfg,
  input  wire logic   head_valid,
  input  wire job_t   head_job,
  output logic        pop,
  output logic        out_valid,
  input  wire logic   out_ready,
  output logic [2:0]  out_kind,
  output logic [1:0]  out_error,
  output logic [15:0] out_peer_send,
  output logic [15:0] out_peer_recv,
  output logic [15:0] out_rx_count,
  output logic [15:0] out_tx_count
);

  logic [15:0] send_counter, send_counter_next;
  logic [15:0] receive_counter, receive_counter_next;
  logic [15:0] acked_rx, acked_rx_next;
  logic [15:0] acked_tx, acked_tx_next;
  logic [2:0]  kind;
  logic [1:0]  err;
  logic [16:0] send_sum;
  logic [16:0] recv_sum;
  logic [15:0] ack_field;
  logic [15:0] seq_field;

  assign pop       = head_valid && (!out_valid || out_ready);
  assign send_sum  = {1'b0, send_counter} + SEQ_STEP;
  assign seq_field = head_job.control[15:0];
  assign ack_field = head_job.control[31:16];
  assign recv_sum  = {1'b0, seq_field} + SEQ_STEP;

  always_comb begin
    send_counter_next    = send_counter;
    receive_counter_next = receive_counter;
    acked_rx_next        = acked_rx;
    acked_tx_next        = acked_tx;
    kind                 = KIND_U;
    err                  = ERR_NONE;
    if (head_job.is_tx) begin
      kind              = KIND_TX;
      send_counter_next = (send_sum > {1'b0, cfg.seq_limit}) ? '0 : send_sum[15:0];
    end else if (head_job.total > cfg.max_frame_len ||
                 head_job.total < {5'b0, cfg.min_frame_len}) begin
      err = ERR_LENGTH;
    end else if (!head_job.control[0]) begin
      // information frame
      kind = KIND_I;
      if (head_job.total < I_FRAME_MIN) begin
        err = ERR_LENGTH;
      end else if (head_job.address != ADDR_BCAST_LO && head_job.address != ADDR_BCAST_HI &&
                   head_job.address != cfg.station_address) begin
        err = ERR_ADDRESS;
      end else begin
        acked_rx_next        = seq_field;
        acked_tx_next        = ack_field;
        receive_counter_next = (recv_sum > {1'b0, cfg.seq_limit}) ? '0 : recv_sum[15:0];
      end
    end else if (!head_job.control[1]) begin
      // supervisory frame
      kind = KIND_S;
      if (head_job.total != SU_FRAME_LEN) begin
        err = ERR_LENGTH;
      end else if (ack_field > send_counter && send_counter != '0) begin
        err = ERR_ACK_HIGH;
      end else begin
        acked_tx_next = ack_field;
      end
    end else if (head_job.total != SU_FRAME_LEN) begin
      err = ERR_LENGTH;
    end
    if (err != ERR_NONE) begin
      kind                 = KIND_ERROR;
      send_counter_next    = '0;
      receive_counter_next = '0;
      acked_rx_next        = '0;
      acked_tx_next        = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      send_counter    <= '0;
      receive_counter <= '0;
      acked_rx        <= '0;
      acked_tx        <= '0;
      out_valid       <= 1'b0;
    end else if (pop) begin
      send_counter    <= send_counter_next;
      receive_counter <= receive_counter_next;
      acked_rx        <= acked_rx_next;
      acked_tx        <= acked_tx_next;
      out_valid       <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind      <= kind;
      out_error     <= err;
      out_peer_send <= acked_rx_next;
      out_peer_recv <= acked_tx_next;
      out_rx_count  <= receive_counter_next;
      out_tx_count  <= send_counter_next;
    end
  end

endmodule

`default_nettype wire

[hdl/apci_frame_checker_unit.sv]
// Top level of the APCI receive frame checker.
// Depends on apcifc_pkg, apcifc_front, apcifc_queue and apcifc_back.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir   Handshake            Content
// s_*       in    s_tvalid/s_tready    tdata: rx_byte; tuser: func
// m_*       out   m_tvalid/m_tready    tdata: check result; tuser: kind
// cfg_*     in    cfg_valid/cfg_ready  register index and write data
//
// One item per cycle is taken while s_tready is high. A byte that closes a frame,
// or a transmit mark, becomes a job in a short queue; the back end resolves the
// job at the queue head and registers its result. It retires one job per cycle
// into the output register unless a result waits on m_tready; while m_tready is
// low the queue fills and s_tready drops once it holds QUEUE_DEPTH jobs.
// Reset is synchronous: parser back to hunting, all counters zero, registers to
// 255, 6, 1 and 65534. No clearing pass is needed.

module apci_frame_checker_unit
  import apcifc_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  // slave stream
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [7:0]           s_tdata,   // [7:0] rx_byte
  input  wire logic [0:0]           s_tuser,   // [0] func
  // master stream
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [71:0]               m_tdata,   // [1:0] error_code, [17:2] peer_send_seq,
                                               // [33:18] peer_recv_seq, [49:34] rx_count,
                                               // [65:50] tx_count, [71:66] zero
  output logic [2:0]                m_tuser,   // [2:0] kind
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [15:0]          cfg_data
);

  cfg_t        cfg;
  logic        accept;
  logic        push;
  job_t        push_job;
  logic        q_full;
  logic        head_valid;
  job_t        head_job;
  logic        pop;
  logic [1:0]  out_error;
  logic [15:0] out_peer_send;
  logic [15:0] out_peer_recv;
  logic [15:0] out_rx_count;
  logic [15:0] out_tx_count;

  // Registers are always writable; the user must write them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_frame_len   <= RST_MAX_FRAME_LEN;
      cfg.min_frame_len   <= RST_MIN_FRAME_LEN;
      cfg.station_address <= RST_STATION_ADDRESS;
      cfg.seq_limit       <= RST_SEQ_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_MAX_FRAME_LEN:   cfg.max_frame_len   <= cfg_data[8:0];
        CFG_MIN_FRAME_LEN:   cfg.min_frame_len   <= cfg_data[3:0];
        CFG_STATION_ADDRESS: cfg.station_address <= cfg_data;
        CFG_SEQ_LIMIT:       cfg.seq_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input is held off only by a full job queue.
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;

  apcifc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .func     (s_tuser[0]),
    .rx_byte  (s_tdata),
    .push     (push),
    .push_job (push_job)
  );

  apcifc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop)
  );

  apcifc_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head_valid    (head_valid),
    .head_job      (head_job),
    .pop           (pop),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_kind      (m_tuser),
    .out_error     (out_error),
    .out_peer_send (out_peer_send),
    .out_peer_recv (out_peer_recv),
    .out_rx_count  (out_rx_count),
    .out_tx_count  (out_tx_count)
  );

  assign m_tdata = {6'b0, out_tx_count, out_rx_count, out_peer_recv, out_peer_send,
                    out_error};

endmodule

`default_nettype wire

[hdl/apcifc_checker.sv]
// Port-level checks of the APCI frame checker, bound to the top level.
// Depends on apcifc_pkg and apci_frame_checker_unit.
`timescale 1ns / 1ps
`default_nettype none

module apcifc_checker
  import apcifc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [71:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // an error clears every counter and carries a code
  a_err_clears: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == KIND_ERROR |-> m_tdata[65:2] == '0 && m_tdata[1:0] != ERR_NONE)
    else $error("error result with counters set or no code");

  // only an error result carries a code
  a_no_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser != KIND_ERROR |-> m_tdata[1:0] == ERR_NONE)
    else $error("error code on a good result");

  // the send count moves in steps of two from zero
  a_tx_even: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[50] == 1'b0)
    else $error("odd send count");

endmodule

bind apci_frame_checker_unit apcifc_checker u_apcifc_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

[sim/apci_result_checker.sv]
// Scoreboard for the APCI frame checker: watches the byte, result and register channels.
// Holds its own model of the parser and counters; depends on apcifc_pkg only.
`timescale 1ns / 1ps

module apci_result_checker
  import apcifc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,
  input  logic [0:0]           s_tuser,
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  input  logic [71:0]          m_tdata,
  input  logic [2:0]           m_tuser,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  output int                   mismatches,
  output int                   awaited
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  err;
    logic [15:0] peer_send;
    logic [15:0] peer_recv;
    logic [15:0] rx_cnt;
    logic [15:0] tx_cnt;
  } apci_report_t;

  apci_report_t pending_reports[$];

  // model copy of registers and parser state
  cfg_t        regs;
  phase_t      phase;
  logic [8:0]  body_pos;
  logic [7:0]  body_len;
  logic [31:0] ctrl_word;
  logic [15:0] asdu_addr;
  logic [15:0] send_cnt;
  logic [15:0] recv_cnt;
  logic [15:0] ack_rx;
  logic [15:0] ack_tx;

  task automatic report_mismatch(input string what);
    if (mismatches < 50)
      $display("%0t ns: %s", $time, what);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  task automatic queue_report(input logic [2:0] kind, input logic [1:0] err);
    pending_reports.push_back('{kind, err, ack_rx, ack_tx, recv_cnt, send_cnt});
  endtask

  // One accepted item through the parser model; queues the report it causes.
  task automatic parse_link_item(input logic func, input logic [7:0] b);
    logic [8:0]  total;
    logic [16:0] sum;
    logic [2:0]  kind;
    logic [1:0]  err;
    if (func) begin
      // local I frame sent: bump send count, parser untouched
      sum = {1'b0, send_cnt} + SEQ_STEP;
      send_cnt = (sum > {1'b0, regs.seq_limit}) ? 16'd0 : sum[15:0];
      queue_report(KIND_TX, ERR_NONE);
    end else begin
      case (phase)
        PH_LEN: begin
          if (b == 8'd0) begin
            phase = PH_HUNT;
            body_pos = 9'd0;
          end else begin
            body_len = b;
            body_pos = 9'd2;
            ctrl_word = 32'd0;
            asdu_addr = 16'd0;
            phase = PH_BODY;
          end
        end
        PH_BODY: begin
          if (body_pos >= 9'd2 && body_pos <= 9'd5)
            ctrl_word[(body_pos - 9'd2) * 8 +: 8] = b;
          else if (body_pos == 9'd10)
            asdu_addr[7:0] = b;
          else if (body_pos == 9'd11)
            asdu_addr[15:8] = b;
          body_pos = body_pos + 9'd1;
          total = {1'b0, body_len} + 9'd2;
          if (body_pos >= total) begin
            phase = PH_HUNT;
            body_pos = 9'd0;
            kind = KIND_ERROR;
            err = ERR_LENGTH;
            if (total > regs.max_frame_len || total < {5'd0, regs.min_frame_len}) begin
              // length error stands
            end else if (!ctrl_word[0]) begin
              if (total < I_FRAME_MIN) begin
              end else if (asdu_addr != ADDR_BCAST_LO && asdu_addr != ADDR_BCAST_HI &&
                           asdu_addr != regs.station_address) begin
                err = ERR_ADDRESS;
              end else begin
                ack_rx = ctrl_word[15:0];
                ack_tx = ctrl_word[31:16];
                sum = {1'b0, ack_rx} + SEQ_STEP;
                recv_cnt = (sum > {1'b0, regs.seq_limit}) ? 16'd0 : sum[15:0];
                kind = KIND_I;
                err = ERR_NONE;
              end
            end else if (!ctrl_word[1]) begin
              if (total != SU_FRAME_LEN) begin
              end else if (ctrl_word[31:16] > send_cnt && send_cnt != 16'd0) begin
                err = ERR_ACK_HIGH;
              end else begin
                ack_tx = ctrl_word[31:16];
                kind = KIND_S;
                err = ERR_NONE;
              end
            end else if (total == SU_FRAME_LEN) begin
              kind = KIND_U;
              err = ERR_NONE;
            end
            if (kind == KIND_ERROR) begin
              send_cnt = 16'd0;
              recv_cnt = 16'd0;
              ack_rx = 16'd0;
              ack_tx = 16'd0;
            end
            queue_report(kind, err);
          end
        end
        default: begin
          if (b == START_BYTE) begin
            phase = PH_LEN;
            body_pos = 9'd1;
          end else begin
            phase = PH_HUNT;
          end
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    apci_report_t want;
    if (rst) begin
      regs = '{RST_MAX_FRAME_LEN, RST_MIN_FRAME_LEN, RST_STATION_ADDRESS, RST_SEQ_LIMIT};
      phase = PH_HUNT;
      body_pos = 9'd0;
      body_len = 8'd0;
      ctrl_word = 32'd0;
      asdu_addr = 16'd0;
      send_cnt = 16'd0;
      recv_cnt = 16'd0;
      ack_rx = 16'd0;
      ack_tx = 16'd0;
      pending_reports.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MAX_FRAME_LEN:   regs.max_frame_len = cfg_data[8:0];
          CFG_MIN_FRAME_LEN:   regs.min_frame_len = cfg_data[3:0];
          CFG_STATION_ADDRESS: regs.station_address = cfg_data;
          CFG_SEQ_LIMIT:       regs.seq_limit = cfg_data;
          default: ;
        endcase
      end
      // results first: none can belong to an item taken at this same edge
      if (m_tvalid && m_tready) begin
        if (pending_reports.size() == 0) begin
          report_mismatch($sformatf("result kind %0d with nothing awaited", m_tuser));
        end else begin
          want = pending_reports.pop_front();
          check_field("kind", 16'(m_tuser), 16'(want.kind));
          check_field("error_code", 16'(m_tdata[1:0]), 16'(want.err));
          check_field("peer_send_seq", m_tdata[17:2], want.peer_send);
          check_field("peer_recv_seq", m_tdata[33:18], want.peer_recv);
          check_field("rx_count", m_tdata[49:34], want.rx_cnt);
          check_field("tx_count", m_tdata[65:50], want.tx_cnt);
        end
      end
      if (s_tvalid && s_tready)
        parse_link_item(s_tuser[0], s_tdata);
    end
    awaited = pending_reports.size();
  end

endmodule

[sim/tb_top.sv]
// Testbench top for apci_frame_checker_unit: clock, reset, byte and register stimulus.
// Depends on apcifc_pkg, the block itself and apci_result_checker for the scoring.
`timescale 1ns / 1ps

module tb_top;
  import apcifc_pkg::*;

  // Picks for the random frame builder
  typedef enum int {
    FRAME_I,
    FRAME_S,
    FRAME_U
  } frame_pick_t;

  localparam int ITEMS_PER_PHASE = 160;
  localparam int SETTLE_CYCLES   = 8;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = 8'd0;  // [7:0] rx_byte
  logic [0:0]           s_tuser = 1'b0;  // [0] func
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [71:0]          m_tdata;         // [1:0] error_code, [17:2] peer_send_seq,
                                         // [33:18] peer_recv_seq, [49:34] rx_count,
                                         // [65:50] tx_count
  logic [2:0]           m_tuser;         // [2:0] kind
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0]          cfg_data = 16'd0;

  int          mismatches;
  int          awaited;
  int          items_sent = 0;
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  logic [15:0] station_now = RST_STATION_ADDRESS;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  apci_frame_checker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  apci_result_checker scoreboard (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .awaited    (awaited)
  );

  // Result side back-pressure; the stall rate is set per phase.
  always @(posedge clk) begin
    if (rst)
      m_tready <= 1'b0;
    else
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // One item on the byte channel. Called just after a rising edge; returns just
  // after the edge that took the item, with tvalid still high so a following
  // item can go out back to back.
  task automatic send_item(input logic func, input logic [7:0] b);
    while ($urandom_range(99) < sender_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= func;
    s_tdata  <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
  endtask

  // A received byte, now and then preceded by a transmit mark so that marks
  // land in the middle of frames as well as between them.
  task automatic send_byte(input logic [7:0] b);
    if ($urandom_range(99) < 4)
      send_item(1'b1, 8'($urandom));
    send_item(1'b0, b);
  endtask

  // Drain: byte channel quiet, every awaited result in, then a settling wait for
  // anything still in the pipe. Sampled on the falling edge, clear of updates.
  task automatic settle();
    s_tvalid <= 1'b0;
    @(negedge clk);
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Only called with the block idle; valid stays up across the four writes.
  task automatic load_regs(input int max_len, input int min_len, input int station,
                           input int limit);
    settle();
    write_reg(CFG_MAX_FRAME_LEN, 16'(max_len));
    write_reg(CFG_MIN_FRAME_LEN, 16'(min_len));
    write_reg(CFG_STATION_ADDRESS, 16'(station));
    write_reg(CFG_SEQ_LIMIT, 16'(limit));
    cfg_valid <= 1'b0;
    station_now = 16'(station);
  endtask

  // A well formed APCI frame with random content. The length is mostly right
  // for the type, sometimes short or long; the address is mostly one that is
  // accepted; S frame acks mostly stay small so they fall under the send count.
  task automatic send_frame();
    frame_pick_t frame_type;
    int          body_len;
    int          roll;
    logic [7:0]  ctrl [4];
    logic [15:0] asdu_addr;
    logic [7:0]  b;
    frame_type = frame_pick_t'($urandom_range(2));
    roll = $urandom_range(99);
    if (frame_type == FRAME_I) begin
      if (roll < 3)
        body_len = $urandom_range(200, 255);
      else if (roll < 15)
        body_len = $urandom_range(1, 9);
      else
        body_len = $urandom_range(10, 20);
    end else begin
      body_len = (roll < 15) ? $urandom_range(1, 8) : 4;
    end
    foreach (ctrl[k]) ctrl[k] = 8'($urandom);
    case (frame_type)
      FRAME_I: ctrl[0][0] = 1'b0;
      FRAME_S: ctrl[0][1:0] = 2'b01;
      default: ctrl[0][1:0] = 2'b11;
    endcase
    if (frame_type == FRAME_S && $urandom_range(99) < 70)
      {ctrl[3], ctrl[2]} = 16'($urandom_range(12));
    roll = $urandom_range(99);
    if (roll < 40)
      asdu_addr = station_now;
    else if (roll < 65)
      asdu_addr = ADDR_BCAST_LO;
    else if (roll < 80)
      asdu_addr = ADDR_BCAST_HI;
    else
      asdu_addr = 16'($urandom);
    send_byte(START_BYTE);
    send_byte(8'(body_len));
    for (int pos = 2; pos < body_len + 2; pos++) begin
      if (pos <= 5)
        b = ctrl[pos-2];
      else if (pos == 10)
        b = asdu_addr[7:0];
      else if (pos == 11)
        b = asdu_addr[15:8];
      else
        b = ($urandom_range(9) == 0) ? START_BYTE : 8'($urandom); // start byte as data
      send_byte(b);
    end
  endtask

  // Opening sequence on reset values, bit 8 is func:
  // start with zero length (skipped), a transmit mark, an S frame acking that
  // mark, a U frame of all-ones bytes, then a minimum I frame to the broadcast
  // address whose receive count wraps from 0xFFFE.
  logic [8:0] opening [$] = '{
    9'h068, 9'h000,
    9'h1FF,
    9'h068, 9'h004, 9'h001, 9'h000, 9'h002, 9'h000,
    9'h068, 9'h004, 9'h0FF, 9'h0FF, 9'h0FF, 9'h0FF,
    9'h068, 9'h00A, 9'h0FE, 9'h0FF, 9'h0FF, 9'h0FF, 9'h000, 9'h000, 9'h000,
    9'h000, 9'h0FF, 9'h0FF
  };

  initial begin
    int phase_end;
    int roll;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (opening[k]) send_item(opening[k][8], opening[k][7:0]);

    // Eight phases, each with a register set and idling pattern:
    // none, sender idle, receiver stall, both - every pattern twice.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: ;                                    // reset values
        1: load_regs(257, 1, 16'h0000, 2);      // widest lengths, fastest wrap
        2: load_regs(12, 12, 16'hFFFF, 65534);  // only 12-byte I frames pass
        3: load_regs(6, 6, $urandom_range(65535), 3);
        7: load_regs(RST_MAX_FRAME_LEN, RST_MIN_FRAME_LEN, RST_STATION_ADDRESS,
                     RST_SEQ_LIMIT);
        default: load_regs($urandom_range(6, 257), $urandom_range(1, 12),
                           $urandom_range(65535),
                           ($urandom_range(1) != 0) ? $urandom_range(2, 40)
                                                    : $urandom_range(2, 65534));
      endcase
      case (p % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin sender_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      phase_end = items_sent + ITEMS_PER_PHASE;
      while (items_sent < phase_end) begin
        roll = $urandom_range(99);
        if (roll < 8) begin
          // line noise between frames
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
        end else if (roll < 13) begin
          send_byte(START_BYTE);
          send_byte(8'h00);
        end else begin
          send_frame();
        end
      end
    end

    settle();
    if (mismatches == 0 && awaited == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

  // Watchdog, far beyond the slowest legal run.
  initial begin
    #1000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
